FILE: design/ulc_pkg.sv
// Shared types, rule table and helpers for the lowercase classifier.
package ulc_pkg;

  localparam int CP_W = 21;

  typedef logic [CP_W-1:0] cp_t;

  // Range qualifiers for a rule
  typedef enum logic [1:0] {
    K_ALL,
    K_ODD,
    K_EVEN,
    K_LOW8
  } rule_kind_t;

  typedef struct packed {
    cp_t        lo;
    cp_t        hi;
    rule_kind_t kind;
    logic       lower;
  } rule_t;

  localparam int RULE_COUNT = 198;
  localparam int GRP_SIZE   = 16;
  localparam int GRP_COUNT  = (RULE_COUNT + GRP_SIZE - 1) / GRP_SIZE;
  localparam int HIT_W      = GRP_COUNT * GRP_SIZE;

  localparam cp_t CP_SHARP_S  = 21'h0000DF;
  localparam cp_t CP_LAST_HIT = 21'h01D7C9;

  typedef logic [HIT_W-1:0]     hit_vec_t;
  typedef logic [GRP_COUNT-1:0] grp_vec_t;

  function automatic rule_t sl(cp_t x);
    return '{lo: x, hi: x, kind: K_ALL, lower: 1'b1};
  endfunction

  function automatic rule_t sn(cp_t x);
    return '{lo: x, hi: x, kind: K_ALL, lower: 1'b0};
  endfunction

  function automatic rule_t rl(cp_t a, cp_t b);
    return '{lo: a, hi: b, kind: K_ALL, lower: 1'b1};
  endfunction

  function automatic rule_t ro(cp_t a, cp_t b);
    return '{lo: a, hi: b, kind: K_ODD, lower: 1'b1};
  endfunction

  function automatic rule_t re(cp_t a, cp_t b);
    return '{lo: a, hi: b, kind: K_EVEN, lower: 1'b1};
  endfunction

  function automatic rule_t r8(cp_t a, cp_t b);
    return '{lo: a, hi: b, kind: K_LOW8, lower: 1'b1};
  endfunction

  // Ordered rule list: the first rule that hits decides
  localparam rule_t RULES [RULE_COUNT] = '{
    rl(21'h61, 21'h7A), sl(CP_SHARP_S), sl(21'hAA), sl(21'hB5), sl(21'hBA), sn(21'hF7),
    rl(21'hE0, 21'hFF), ro(21'h100, 21'h137), re(21'h138, 21'h148), ro(21'h148, 21'h177),
    sl(21'h17A), sl(21'h17C), sl(21'h17E), sl(21'h17F), sl(21'h180), sl(21'h183),
    sl(21'h185), sl(21'h188), sl(21'h18C), sl(21'h18D), sl(21'h192), sl(21'h195),
    sl(21'h199), sl(21'h19A), sl(21'h19B), sl(21'h19E), sl(21'h1A1), sl(21'h1A3),
    sl(21'h1A5), sl(21'h1A8), sl(21'h1AA), sl(21'h1AB), sl(21'h1AD), sl(21'h1B0),
    sl(21'h1B4), sl(21'h1B6), sl(21'h1B9), sl(21'h1BA), sl(21'h1BD), sl(21'h1BE),
    sl(21'h1BF), sl(21'h1C5), sl(21'h1C6), sl(21'h1C8), sl(21'h1C9), sl(21'h1CC),
    sl(21'h1CB), sl(21'h1CE), re(21'h1D0, 21'h1DC), sl(21'h1F0), sn(21'h1F1),
    sl(21'h1F2), sn(21'h1F7), sl(21'h221), ro(21'h1DD, 21'h233), rl(21'h234, 21'h239),
    sl(21'h23C), sl(21'h23F), sl(21'h240), sl(21'h242), sl(21'h247), sl(21'h249),
    sl(21'h24B), sl(21'h24D), sl(21'h24F), sl(21'h294), rl(21'h250, 21'h2B8),
    sl(21'h2C0), sl(21'h2C1), sl(21'h2E0), sl(21'h2E1), sl(21'h2E2), sl(21'h2E3),
    sl(21'h2E4), sl(21'h345), sl(21'h371), sl(21'h373), sl(21'h377), sl(21'h37A),
    sl(21'h37B), sl(21'h37C), sl(21'h37D), sl(21'h3F8), sl(21'h3FB), sl(21'h3FC),
    sl(21'h390), rl(21'h3AC, 21'h3CE), sl(21'h3D0), sn(21'h3D3), sl(21'h3D6),
    ro(21'h3D0, 21'h3EF), sl(21'h3F0), sl(21'h3F1), sl(21'h3F2), sl(21'h3F3),
    sl(21'h3F5),
    rl(21'h430, 21'h45F), sn(21'h483), sn(21'h485), sn(21'h487), sn(21'h489),
    ro(21'h460, 21'h4BF), sl(21'h4CF), re(21'h4C1, 21'h4CF), sl(21'h4FB), sl(21'h4FD),
    sl(21'h4FF), ro(21'h4D0, 21'h4F9), ro(21'h500, 21'h50F), ro(21'h510, 21'h52F),
    sl(21'h560), rl(21'h561, 21'h588),
    sn(21'h10FB), sn(21'h10FC), rl(21'h10D0, 21'h10FF),
    rl(21'h13F8, 21'h13FD), rl(21'h1C80, 21'h1C88), rl(21'h1D00, 21'h1DBF),
    sn(21'h1E9E), rl(21'h1E96, 21'h1E9F), sl(21'h1EFB), sl(21'h1EFD), sl(21'h1EFF),
    ro(21'h1E00, 21'h1EFF), sn(21'h1F16), sn(21'h1F17), sn(21'h1F46), sn(21'h1F47),
    sl(21'h1F78), sl(21'h1F79), sl(21'h1F7A), sl(21'h1F7B), sl(21'h1F7C),
    sl(21'h1F7D), sn(21'h1FB5), sl(21'h1FBE), sn(21'h1FC0), sn(21'h1FC1),
    sn(21'h1FC5), sn(21'h1FD4), sn(21'h1FD5), sn(21'h1FF0), sn(21'h1FF1),
    sn(21'h1FF5), r8(21'h1F00, 21'h1FFF),
    sl(21'h2071), sl(21'h207F), rl(21'h2090, 21'h209C),
    sl(21'h210A), sl(21'h210E), sl(21'h210F), sl(21'h2113), sl(21'h212F),
    sl(21'h2134), sl(21'h2139), sl(21'h213C), sl(21'h213D), sl(21'h2146),
    sl(21'h2147), sl(21'h2148), sl(21'h2149), sl(21'h214E), rl(21'h2170, 21'h217F),
    sl(21'h2184), rl(21'h24D0, 21'h24E9), rl(21'h2C30, 21'h2C5F),
    rl(21'hFB00, 21'hFB06), rl(21'hFB13, 21'hFB17), rl(21'hFF41, 21'hFF5A),
    rl(21'h10428, 21'h1044D),
    rl(21'h1D41A, 21'h1D433), sn(21'h1D455), rl(21'h1D44E, 21'h1D467),
    rl(21'h1D482, 21'h1D49B), sn(21'h1D4BA), sn(21'h1D4BC), sn(21'h1D4C1),
    sn(21'h1D4C4), rl(21'h1D4B6, 21'h1D4CF), rl(21'h1D4EA, 21'h1D503),
    rl(21'h1D51E, 21'h1D537), rl(21'h1D552, 21'h1D56B), rl(21'h1D586, 21'h1D59F),
    rl(21'h1D5BA, 21'h1D5D3), rl(21'h1D5EE, 21'h1D607), rl(21'h1D622, 21'h1D63B),
    rl(21'h1D656, 21'h1D66F), rl(21'h1D68A, 21'h1D6A3),
    rl(21'h1D6C2, 21'h1D6DA), rl(21'h1D6DC, 21'h1D6E1), rl(21'h1D6FC, 21'h1D714),
    rl(21'h1D716, 21'h1D71B), rl(21'h1D736, 21'h1D74E), rl(21'h1D750, 21'h1D755),
    rl(21'h1D770, 21'h1D788), rl(21'h1D78A, 21'h1D78F), rl(21'h1D7AA, 21'h1D7C2),
    rl(21'h1D7C4, CP_LAST_HIT)
  };

  // Does rule idx hit the code point; padding slots never hit
  function automatic logic rule_hit_at(int idx, cp_t cp);
    rule_t r;
    logic  in_range;
    logic  qual;
    if (idx >= RULE_COUNT) begin
      return 1'b0;
    end
    r        = RULES[idx];
    in_range = (cp >= r.lo) && (cp <= r.hi);
    unique case (r.kind)
      K_ODD:   qual = cp[0];
      K_EVEN:  qual = !cp[0];
      K_LOW8:  qual = !cp[3];
      default: qual = 1'b1;
    endcase
    return in_range && qual;
  endfunction

  function automatic logic rule_lower_at(int idx);
    if (idx >= RULE_COUNT) begin
      return 1'b0;
    end
    return RULES[idx].lower;
  endfunction

endpackage

FILE: design/ulc_if.sv
// Stream interfaces for code points in and lowercase flags out.
interface ulc_cp_if;
  logic                 valid;
  logic                 ready;
  logic [ulc_pkg::CP_W-1:0] code_point;

  modport source (output valid, output code_point, input ready);
  modport sink   (input valid, input code_point, output ready);
endinterface

interface ulc_lower_if;
  logic valid;
  logic ready;
  logic is_lower;

  modport source (output valid, output is_lower, input ready);
  modport sink   (input valid, input is_lower, output ready);
endinterface

FILE: design/unicode_lowercase_classifier.sv
// Four-stage pipeline: input register, rule compare, group priority, final pick.
// An accepted code point is registered in cp1, then in hit2, then in the group registers, then in lower4.
// Throughput: one code point per cycle; each stage holds while the next is full and cannot advance.
// The rule compare stage sets the depth: 198 range tests, then 16-wide groups.
// Reset (rst, synchronous) empties every stage; the data registers are not reset.
module unicode_lowercase_classifier (
  input logic              clk,
  input logic              rst,
  ulc_cp_if.sink           req,
  ulc_lower_if.source      rsp
);
  import ulc_pkg::*;

  logic     v1, v2, v3, v4;
  logic     adv1, adv2, adv3, adv4;
  cp_t      cp1;
  hit_vec_t hits_c, hit2;
  grp_vec_t grp_any_c, grp_val_c, grp_any3, grp_val3;
  logic     lower_c, lower4;

  // A stage advances when it is empty or the stage after it advances
  assign adv4      = !v4 || rsp.ready;
  assign adv3      = !v3 || adv4;
  assign adv2      = !v2 || adv3;
  assign adv1      = !v1 || adv2;
  assign req.ready = adv1;

  ulc_rule_match u_match (
    .cp   (cp1),
    .hits (hits_c)
  );

  // Lowest-indexed hit inside each group wins
  always_comb begin
    for (int g = 0; g < GRP_COUNT; g++) begin
      grp_any_c[g] = 1'b0;
      grp_val_c[g] = 1'b0;
      for (int i = GRP_SIZE - 1; i >= 0; i--) begin
        if (hit2[g*GRP_SIZE + i]) begin
          grp_any_c[g] = 1'b1;
          grp_val_c[g] = rule_lower_at(g*GRP_SIZE + i);
        end
      end
    end
  end

  // Lowest-indexed group with a hit wins
  always_comb begin
    lower_c = 1'b0;
    for (int g = GRP_COUNT - 1; g >= 0; g--) begin
      if (grp_any3[g]) begin
        lower_c = grp_val3[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= req.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && req.valid) cp1 <= req.code_point;
    if (adv2 && v1) hit2 <= hits_c;
    if (adv3 && v2) begin
      grp_any3 <= grp_any_c;
      grp_val3 <= grp_val_c;
    end
    if (adv4 && v3) lower4 <= lower_c;
  end

  assign rsp.valid    = v4;
  assign rsp.is_lower = lower4;

  a_no_hit_past_table: assert property (@(posedge clk) disable iff (rst)
    (v1 && adv2 && cp1 > CP_LAST_HIT) |=> (hit2 == '0))
    else $error("rule hit beyond last table entry");

  a_sharp_s_hits: assert property (@(posedge clk) disable iff (rst)
    (v1 && adv2 && cp1 == CP_SHARP_S) |=> (hit2[1] && !hit2[0]))
    else $error("sharp s rule did not hit");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (v1 && v2 && v3 && v4 && !rsp.ready))
    else $error("input stalled with a free stage");

  a_group_needs_hit: assert property (@(posedge clk) disable iff (rst)
    (v2 && adv3 && hit2 == '0) |=> (grp_any3 == '0))
    else $error("group flag set without any rule hit");

endmodule

FILE: design/ulc_rule_match.sv
// Parallel rule comparators: one hit bit per rule for a code point.
module ulc_rule_match (
  input  ulc_pkg::cp_t     cp,
  output ulc_pkg::hit_vec_t hits
);
  import ulc_pkg::*;

  always_comb begin
    for (int i = 0; i < HIT_W; i++) begin
      hits[i] = rule_hit_at(i, cp);
    end
  end

endmodule
